// ===== sv/ptw_pkg.sv =====
`default_nettype none

package ptw_pkg;

  localparam int unsigned NUM_TABLES_DEF = 16;
  localparam int unsigned ENTRY_W        = 64;
  localparam int unsigned IDX_W          = 9;
  localparam int unsigned PRESENT_BIT    = 0;
  localparam int unsigned WRITABLE_BIT   = 1;

  typedef enum logic [1:0] {
    KIND_MAP   = 2'd0,
    KIND_UNMAP = 2'd1,
    KIND_XLATE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_MISALIGNED    = 3'd1,
    ST_ALREADY       = 3'd2,
    ST_NOT_MAPPED    = 3'd3,
    ST_OUT_OF_TABLES = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ===== sv/ptw_store.sv =====
`default_nettype none

module ptw_store #(
  parameter int unsigned NUM_TABLES = ptw_pkg::NUM_TABLES_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire ptw_pkg::mem_cmd_t                          cmd,
  input  wire logic [$clog2(NUM_TABLES)+ptw_pkg::IDX_W-1:0] addr,
  input  wire logic [ptw_pkg::ENTRY_W-1:0]                wdata,
  output logic      [ptw_pkg::ENTRY_W-1:0]                rdata,
  output logic                                            clear_done
);
  import ptw_pkg::*;

  localparam int unsigned AW    = $clog2(NUM_TABLES) + IDX_W;
  localparam int unsigned DEPTH = NUM_TABLES * (1 << IDX_W);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      clr_addr;
  logic               clearing;

  // zeroing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  assign clear_done = ~clearing;

endmodule

`default_nettype wire

// ===== sv/page_table_walker.sv =====
// Four-level page table walker with an internal store of 4 KiB tables.
// Input channel (in_valid/in_ready) carries kind, virt_addr, phys_addr and
// flags; output channel (out_valid/out_ready) returns ok, status,
// phys_result and flush_tlb, one result item per input item.
// cfg_we/cfg_wdata writes table_base_address; write only while idle.
// After reset the table store is zeroed by a sweep over all NUM_TABLES*512
// entries, during which in_ready stays low. The allocation counter restarts
// at table 1 and the base address returns to 0.
// Each walk level is a read of the single-port store (S_READ) followed by
// an evaluation of the entry (S_EVAL), which writes a new link or the leaf
// entry if needed; after the last level, or when the walk stops early,
// S_DONE hands the result over. A misaligned or reserved item goes straight
// to S_DONE. The walker takes a new item only once the result of the last
// one has been loaded into the output register.
// The result sits in an output register: the next item is accepted and
// walked while it waits. When the receiver stalls with a result still
// held, the walker finishes the next item and waits before loading it.
`default_nettype none

module page_table_walker #(
  parameter int unsigned NUM_TABLES = ptw_pkg::NUM_TABLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [51:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [47:0] virt_addr,
  input  wire logic [51:0] phys_addr,
  input  wire logic [63:0] flags,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [2:0]       status,
  output logic [51:0]      phys_result,
  output logic             flush_tlb
);
  import ptw_pkg::*;

  localparam int unsigned TW = $clog2(NUM_TABLES);
  localparam int unsigned AW = TW + IDX_W;

  state_t          state, state_next;
  logic [1:0]      lvl, lvl_next;
  logic [TW-1:0]   tbl, tbl_next;
  logic [TW:0]     next_free, next_free_next;
  logic [51:0]     base;
  kind_t           kind_r;
  logic [47:0]     va_r;
  logic [51:0]     pa_r;
  logic [63:0]     fl_r;
  status_t         st_r, st_next;
  logic [51:0]     res_r, res_next;
  logic            flush_r, flush_next;

  mem_cmd_t        cmd;
  logic [AW-1:0]   mem_addr;
  logic [63:0]     wdata, rdata;
  logic            clear_done;

  logic [IDX_W-1:0] lvl_idx;
  logic [39:0]      link_off;
  logic             link_ok;
  logic             accept, emit;

  ptw_store #(.NUM_TABLES(NUM_TABLES)) u_store (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .addr       (mem_addr),
    .wdata      (wdata),
    .rdata      (rdata),
    .clear_done (clear_done)
  );

  always_comb begin
    case (lvl)
      2'd0:    lvl_idx = va_r[47:39];
      2'd1:    lvl_idx = va_r[38:30];
      2'd2:    lvl_idx = va_r[29:21];
      default: lvl_idx = va_r[20:12];
    endcase
  end

  assign mem_addr = {tbl, lvl_idx};

  // link must name a table already handed out
  assign link_off = rdata[51:12] - base[51:12];
  assign link_ok  = (link_off[39:TW+1] == '0) && (link_off[TW:0] < next_free);

  assign in_ready = (state == S_IDLE) && clear_done;
  assign accept   = in_valid && in_ready;
  assign emit     = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_free <= (TW+1)'(1);
      base      <= '0;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      if (cfg_we) begin
        base <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl     <= lvl_next;
    tbl     <= tbl_next;
    st_r    <= st_next;
    res_r   <= res_next;
    flush_r <= flush_next;
    if (accept) begin
      kind_r <= kind_t'(kind);
      va_r   <= virt_addr;
      pa_r   <= phys_addr;
      fl_r   <= flags;
    end
  end

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    tbl_next       = tbl;
    next_free_next = next_free;
    st_next        = st_r;
    res_next       = res_r;
    flush_next     = flush_r;
    cmd            = '0;
    wdata          = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          lvl_next   = 2'd0;
          tbl_next   = '0;
          res_next   = '0;
          flush_next = 1'b0;
          st_next    = ST_OK;
          case (kind_t'(kind))
            KIND_MAP: begin
              if (virt_addr[11:0] != '0 || phys_addr[11:0] != '0) begin
                st_next    = ST_MISALIGNED;
                state_next = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            KIND_UNMAP: begin
              if (virt_addr[11:0] != '0) begin
                st_next    = ST_MISALIGNED;
                state_next = S_DONE;
              end else begin
                state_next = S_READ;
              end
            end
            KIND_XLATE: state_next = S_READ;
            default: begin
              st_next    = ST_NOT_MAPPED;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (lvl != 2'd3) begin
          if (rdata[PRESENT_BIT]) begin
            if (link_ok) begin
              tbl_next   = link_off[TW-1:0];
              lvl_next   = lvl + 2'd1;
              state_next = S_READ;
            end else begin
              st_next    = ST_NOT_MAPPED;
              state_next = S_DONE;
            end
          end else if (kind_r != KIND_MAP) begin
            st_next    = ST_NOT_MAPPED;
            state_next = S_DONE;
          end else if (next_free == (TW+1)'(NUM_TABLES)) begin
            st_next    = ST_OUT_OF_TABLES;
            state_next = S_DONE;
          end else begin
            cmd.wr = 1'b1;
            wdata  = {12'd0, base[51:12] + 40'(next_free), 12'd0};
            wdata[PRESENT_BIT]  = 1'b1;
            wdata[WRITABLE_BIT] = 1'b1;
            tbl_next       = next_free[TW-1:0];
            next_free_next = next_free + (TW+1)'(1);
            lvl_next       = lvl + 2'd1;
            state_next     = S_READ;
          end
        end else begin
          state_next = S_DONE;
          case (kind_r)
            KIND_MAP: begin
              if (rdata[PRESENT_BIT]) begin
                st_next = ST_ALREADY;
              end else begin
                cmd.wr = 1'b1;
                wdata  = {12'd0, pa_r[51:12], 12'd0} | fl_r;
                wdata[PRESENT_BIT] = 1'b1;
              end
            end
            KIND_UNMAP: begin
              if (rdata[PRESENT_BIT]) begin
                cmd.wr     = 1'b1;
                flush_next = 1'b1;
              end else begin
                st_next = ST_NOT_MAPPED;
              end
            end
            default: begin
              if (rdata[PRESENT_BIT]) begin
                res_next = {rdata[51:12], va_r[11:0]};
              end else begin
                st_next = ST_NOT_MAPPED;
              end
            end
          endcase
        end
      end
      S_DONE: begin
        if (emit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ok          <= (st_r == ST_OK);
      status      <= st_r;
      phys_result <= res_r;
      flush_tlb   <= flush_r;
    end
  end

`ifndef SYNTHESIS
  a_ready_after_clear: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> clear_done)
    else $error("item taken during store clearing");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    next_free != '0 && next_free <= (TW+1)'(NUM_TABLES))
    else $error("table allocation counter out of range");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (status == ST_OK)))
    else $error("ok disagrees with status");

  a_extras_need_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (flush_tlb || phys_result != '0) |-> ok)
    else $error("flush or translation on a failed item");

  a_port_use: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd && cmd.wr) && !(cmd.wr && kind_r == KIND_XLATE))
    else $error("illegal store access");
`endif

endmodule

`default_nettype wire

// ===== sim/page_table_walker_checker.sv =====
module page_table_walker_checker #(
  parameter int unsigned NUM_TABLES = ptw_pkg::NUM_TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [51:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [63:0] flags,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        ok,
  input  logic [2:0]  status,
  input  logic [51:0] phys_result,
  input  logic        flush_tlb,
  output int          errors,
  output int          outstanding,
  output int          n_checked,
  output int          n_done,
  output int          n_misaligned,
  output int          n_already,
  output int          n_unmapped,
  output int          n_no_table,
  output int          n_flushed
);
  import ptw_pkg::*;

  localparam logic [63:0] FRAME_MASK   = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] PRESENT_MASK = 64'd1 << PRESENT_BIT;
  localparam logic [63:0] LINK_BITS    = PRESENT_MASK | (64'd1 << WRITABLE_BIT);
  localparam int unsigned SLOTS        = 512;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [51:0] phys;
    logic        flush;
  } walk_result_t;

  logic [63:0]  shadow_tables [NUM_TABLES*SLOTS];
  int unsigned  shadow_next;
  logic [51:0]  shadow_base;
  walk_result_t pending_results [$];

  // A present link must name a table already handed out, else the walk dies.
  function automatic bit follow_link(input logic [63:0] entry, output int unsigned tbl);
    logic [63:0] span;
    span = ((entry & FRAME_MASK) - ({12'b0, shadow_base} & FRAME_MASK)) & FRAME_MASK;
    tbl = 0;
    if (span[63:12] >= shadow_next || span[63:12] >= NUM_TABLES) return 1'b0;
    tbl = span[43:12];
    return 1'b1;
  endfunction

  function automatic status_t walk_to_leaf(input logic [47:0] va, input bit create,
                                           output int unsigned leaf);
    int unsigned tbl;
    int unsigned nxt;
    int unsigned slot;
    logic [63:0] entry;
    tbl  = 0;
    leaf = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      slot  = tbl * SLOTS + 32'(9'(va >> (39 - 9 * lvl)));
      entry = shadow_tables[slot];
      if (entry[PRESENT_BIT]) begin
        if (!follow_link(entry, nxt)) return ST_NOT_MAPPED;
        tbl = nxt;
      end else begin
        if (!create) return ST_NOT_MAPPED;
        if (shadow_next >= NUM_TABLES) return ST_OUT_OF_TABLES;
        shadow_tables[slot] = ((({12'b0, shadow_base} & FRAME_MASK) + (64'(shadow_next) << 12))
                               & FRAME_MASK) | LINK_BITS;
        tbl = shadow_next;
        shadow_next++;
      end
    end
    leaf = tbl * SLOTS + 32'(va[20:12]);
    return ST_OK;
  endfunction

  function automatic walk_result_t item_outcome(input kind_t k, input logic [47:0] va,
                                                input logic [51:0] pa, input logic [63:0] fl);
    walk_result_t r;
    int unsigned leaf;
    r.ok     = 1'b0;
    r.status = ST_NOT_MAPPED;
    r.phys   = '0;
    r.flush  = 1'b0;
    case (k)
      KIND_MAP: begin
        if (va[11:0] != 0 || pa[11:0] != 0) begin
          r.status = ST_MISALIGNED;
        end else begin
          r.status = walk_to_leaf(va, 1'b1, leaf);
          if (r.status == ST_OK) begin
            if (shadow_tables[leaf][PRESENT_BIT]) r.status = ST_ALREADY;
            else shadow_tables[leaf] = ({12'b0, pa} & FRAME_MASK) | fl | PRESENT_MASK;
          end
        end
      end
      KIND_UNMAP: begin
        if (va[11:0] != 0) begin
          r.status = ST_MISALIGNED;
        end else begin
          r.status = walk_to_leaf(va, 1'b0, leaf);
          if (r.status == ST_OK) begin
            if (shadow_tables[leaf][PRESENT_BIT]) begin
              shadow_tables[leaf] = '0;
              r.flush = 1'b1;
            end else begin
              r.status = ST_NOT_MAPPED;
            end
          end
        end
      end
      KIND_XLATE: begin
        r.status = walk_to_leaf(va, 1'b0, leaf);
        if (r.status == ST_OK) begin
          if (shadow_tables[leaf][PRESENT_BIT])
            r.phys = 52'((shadow_tables[leaf] & FRAME_MASK) | {52'b0, va[11:0]});
          else
            r.status = ST_NOT_MAPPED;
        end
      end
      default: ;
    endcase
    r.ok = (r.status == ST_OK);
    return r;
  endfunction

  always @(posedge clk) begin
    walk_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_TABLES * SLOTS; i++) shadow_tables[i] = '0;
      shadow_next  = 1;
      shadow_base  = '0;
      pending_results.delete();
      errors       = 0;
      n_checked    = 0;
      n_done       = 0;
      n_misaligned = 0;
      n_already    = 0;
      n_unmapped   = 0;
      n_no_table   = 0;
      n_flushed    = 0;
    end else begin
      if (cfg_we) shadow_base = cfg_wdata;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, status %0d phys %h", $time, status,
                   phys_result);
        end else begin
          want = pending_results.pop_front();
          if (ok !== want.ok) begin
            errors++;
            $display("%0t: item %0d ok expected %0d got %0d", $time, n_checked, want.ok, ok);
          end
          if (status !== want.status) begin
            errors++;
            $display("%0t: item %0d status expected %0d got %0d", $time, n_checked,
                     want.status, status);
          end
          if (phys_result !== want.phys) begin
            errors++;
            $display("%0t: item %0d phys_result expected %h got %h", $time, n_checked,
                     want.phys, phys_result);
          end
          if (flush_tlb !== want.flush) begin
            errors++;
            $display("%0t: item %0d flush_tlb expected %0d got %0d", $time, n_checked,
                     want.flush, flush_tlb);
          end
          case (want.status)
            ST_OK:            n_done++;
            ST_MISALIGNED:    n_misaligned++;
            ST_ALREADY:       n_already++;
            ST_NOT_MAPPED:    n_unmapped++;
            ST_OUT_OF_TABLES: n_no_table++;
            default: ;
          endcase
          if (want.flush) n_flushed++;
          n_checked++;
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(item_outcome(kind_t'(kind), virt_addr, phys_addr, flags));
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== sim/page_table_walker_test.sv =====
module page_table_walker_test;
  import ptw_pkg::*;

  localparam int unsigned NUM_TABLES   = NUM_TABLES_DEF;
  localparam int          DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [51:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [47:0] virt_addr;
  logic [51:0] phys_addr;
  logic [63:0] flags;
  logic        out_valid;
  logic        out_ready;
  logic        ok;
  logic [2:0]  status;
  logic [51:0] phys_result;
  logic        flush_tlb;

  int errors;
  int outstanding;
  int n_checked;
  int n_done;
  int n_misaligned;
  int n_already;
  int n_unmapped;
  int n_no_table;
  int n_flushed;

  bit          jitter;
  logic [47:0] seed_va [7];

  page_table_walker #(.NUM_TABLES(NUM_TABLES)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .virt_addr(virt_addr), .phys_addr(phys_addr), .flags(flags),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .status(status), .phys_result(phys_result), .flush_tlb(flush_tlb)
  );

  page_table_walker_checker #(.NUM_TABLES(NUM_TABLES)) walk_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .virt_addr(virt_addr), .phys_addr(phys_addr), .flags(flags),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .status(status), .phys_result(phys_result), .flush_tlb(flush_tlb),
    .errors(errors), .outstanding(outstanding), .n_checked(n_checked), .n_done(n_done),
    .n_misaligned(n_misaligned), .n_already(n_already), .n_unmapped(n_unmapped),
    .n_no_table(n_no_table), .n_flushed(n_flushed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 600000);
    $display("page_table_walker regression: fail");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input kind_t k, input logic [47:0] va, input logic [51:0] pa,
                           input logic [63:0] fl);
    int gap;
    gap = (jitter && $urandom_range(0, 1) == 1) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    kind      = k;
    virt_addr = va;
    phys_addr = pa;
    flags     = fl;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly walks under pages already set up, with a varied leaf index.
  task automatic send_random_item();
    kind_t       k;
    logic [47:0] va;
    logic [51:0] pa;
    logic [63:0] fl;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) k = KIND_MAP;
    else if (pick < 60) k = KIND_UNMAP;
    else if (pick < 95) k = KIND_XLATE;
    else k = KIND_RSVD;
    if ($urandom_range(0, 9) < 8) begin
      va = seed_va[$urandom_range(0, 6)];
      va[20:12] = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 7));
    end else begin
      va = 48'({$urandom, $urandom});
      va[11:0] = 12'h0;
    end
    if (k == KIND_XLATE || $urandom_range(0, 19) == 0) va[11:0] = 12'($urandom);
    pa = 52'({$urandom, $urandom});
    if ($urandom_range(0, 19) != 0) pa[11:0] = 12'h0;
    fl = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : 64'h0;
    send_item(k, va, pa, fl);
  endtask

  task automatic drain_walker();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_table_base(input logic [51:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (jitter && $urandom_range(0, 4) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin
    logic [51:0] phase_base [5];
    int          phase_len [5];
    bit          phase_jitter [5];
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    kind      = KIND_MAP;
    virt_addr = '0;
    phys_addr = '0;
    flags     = '0;
    jitter    = 1'b0;
    seed_va   = '{48'h0000_0000_0000, 48'hFFFF_FFFF_F000, 48'h0000_4000_0000,
                  48'h0080_0000_0000, 48'h0100_0000_0000, 48'h0180_0000_0000,
                  48'h0200_0000_0000};
    phase_base   = '{52'h0, 52'hF_FFFF_FFFF_FFFF, 52'h0_0000_0000_1ABC,
                     52'({$urandom, $urandom}), 52'h0};
    phase_len    = '{150, 80, 80, 60, 130};
    phase_jitter = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    repeat (5) @(negedge clk);
    rst = 1'b0;

    send_item(KIND_XLATE, 48'h0, 52'h0, 64'h0);
    send_item(KIND_UNMAP, 48'h0, 52'h0, 64'h0);
    send_item(KIND_MAP, 48'h1, 52'h0, 64'h0);
    send_item(KIND_MAP, 48'h0, 52'h800, 64'h0);
    send_item(KIND_UNMAP, 48'hFFF, 52'h0, 64'h0);
    send_item(KIND_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, '1);
    send_item(KIND_XLATE, 48'hFFF, 52'h0, 64'h0);
    send_item(KIND_MAP, 48'h0, 52'h3000, 64'h0);
    send_item(KIND_UNMAP, 48'h0, 52'h0, 64'h0);
    send_item(KIND_XLATE, 48'h123, 52'h0, 64'h0);
    send_item(KIND_MAP, 48'hFFFF_FFFF_F000, 52'h1000, 64'h0);
    send_item(KIND_XLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0);
    send_item(KIND_RSVD, '1, '1, '1);
    send_item(KIND_XLATE, 48'hFFFF_FFFF_F001, '1, '1);
    // fresh top- and second-level slots use up the remaining tables, the fourth one part way
    send_item(KIND_MAP, 48'h0000_4000_0000, 52'h2000, 64'h2);
    send_item(KIND_MAP, 48'h0080_0000_0000, 52'h4000, 64'h0);
    send_item(KIND_MAP, 48'h0100_0000_0000, 52'h5000, 64'h0);
    send_item(KIND_MAP, 48'h0180_0000_0000, 52'h6000, 64'h0);
    send_item(KIND_MAP, 48'h0200_0000_0000, 52'h7000, 64'h0);
    send_item(KIND_XLATE, 48'h0180_0000_0000, 52'h0, 64'h0);
    send_item(KIND_UNMAP, 48'h0080_0000_0000, 52'h0, 64'h0);
    send_item(KIND_XLATE, 48'h0080_0000_0ABC, 52'h0, 64'h0);
    send_item(KIND_MAP, 48'h0, 52'h0, 64'h0);
    send_item(KIND_XLATE, 48'h0, 52'h0, 64'h0);

    for (int p = 0; p < 5; p++) begin
      drain_walker();
      write_table_base(phase_base[p]);
      jitter = phase_jitter[p];
      repeat (phase_len[p]) send_random_item();
    end
    drain_walker();

    $display("Checked %0d walker items across several table bases: %0d done, %0d TLB flushes",
             n_checked, n_done, n_flushed);
    $display("Refused: %0d misaligned, %0d already mapped, %0d not mapped, %0d out of tables",
             n_misaligned, n_already, n_unmapped, n_no_table);
    if (errors == 0 && outstanding == 0)
      $display("page_table_walker regression: pass");
    else
      $display("page_table_walker regression: fail");
    $finish;
  end

endmodule

// ===== page_table_walker.f =====
sv/ptw_pkg.sv
sv/ptw_store.sv
sv/page_table_walker.sv
sim/page_table_walker_checker.sv
sim/page_table_walker_test.sv
